@@ rtl/nnsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared types, register indexes and constants for the nearest-neighbor
// scale address generator.
// ----------------------------------------------------------------------------
package nnsa_pkg;

   // Fixed field widths of the block's ports.
   localparam int COORD_W     = 12;
   localparam int DIM_REG_W   = 13;
   localparam int OFFSET_W    = 16;
   localparam int ADDR_W      = 26;
   localparam int PAD_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 56;

   // Reset values of the configuration registers.
   localparam logic [DIM_REG_W-1:0] DIM_RESET    = 13'd1;
   localparam logic [OFFSET_W-1:0]  OFFSET_RESET = 16'd54;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH   = 3'd0,
      CSR_SRC_HEIGHT  = 3'd1,
      CSR_SRC_TOPDOWN = 3'd2,
      CSR_DST_WIDTH   = 3'd3,
      CSR_DST_HEIGHT  = 3'd4,
      CSR_PIXEL_OFS   = 3'd5
   } nnsa_csr_type;

   // Per-beat control that travels alongside the division lanes.
   typedef struct packed {
      logic             ok;
      logic             row_end;
      logic [PAD_W-1:0] dst_pad;
   } nnsa_ctl_type;

   // Padding of a 24-bit row: (4 - 3w mod 4) mod 4, which equals w mod 4.
   function automatic logic [PAD_W-1:0] row_pad(input logic [PAD_W-1:0] w_lsbs);
      return w_lsbs;
   endfunction

endpackage

@@ rtl/nnsa_front.sv @@
// ----------------------------------------------------------------------------
// nnsa_front
// Entry stage: range check, row-end flags and the two products that feed
// the division chain.
// ----------------------------------------------------------------------------
module nnsa_front import nnsa_pkg::*; #(
   parameter int DIM_W = 13,
   parameter int QUO_W = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [COORD_W-1:0] out_row,
   input  logic [COORD_W-1:0] out_col,
   input  logic [DIM_W-1:0]   src_w,
   input  logic [DIM_W-1:0]   src_h,
   input  logic [DIM_W-1:0]   dst_w,
   input  logic [DIM_W-1:0]   dst_h,
   output logic               out_valid,
   input  logic               out_ready,
   output nnsa_ctl_type       out_ctl,
   output logic [DIM_W-1:0]   out_rem_row,
   output logic [QUO_W-1:0]   out_shr_row,
   output logic [DIM_W-1:0]   out_rem_col,
   output logic [QUO_W-1:0]   out_shr_col
);

   localparam int PROD_W = COORD_W + DIM_W;

   logic               valid_ff;
   nnsa_ctl_type       ctl_ff, ctl_in;
   logic [PROD_W-1:0]  prod_row_in, prod_col_in;
   logic [DIM_W-1:0]   rem_row_ff, rem_col_ff;
   logic [QUO_W-1:0]   shr_row_ff, shr_col_ff;

   assign in_ready = !valid_ff || out_ready;

   // Numerators and the flags that depend only on the coordinate.
   always_comb begin
      prod_row_in     = PROD_W'(out_row) * PROD_W'(src_h);
      prod_col_in     = PROD_W'(out_col) * PROD_W'(src_w);
      ctl_in.ok       = (PROD_W'(out_row) < PROD_W'(dst_h)) &&
                        (PROD_W'(out_col) < PROD_W'(dst_w));
      ctl_in.row_end  = (PROD_W'(out_col) == (PROD_W'(dst_w) - PROD_W'(1)));
      ctl_in.dst_pad  = ctl_in.row_end ? row_pad(dst_w[PAD_W-1:0]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // The high part of each numerator is already below the divisor, so it
   // seeds the partial remainder; the low part shifts in one bit per cell.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff     <= ctl_in;
         rem_row_ff <= DIM_W'(prod_row_in >> QUO_W);
         shr_row_ff <= prod_row_in[QUO_W-1:0];
         rem_col_ff <= DIM_W'(prod_col_in >> QUO_W);
         shr_col_ff <= prod_col_in[QUO_W-1:0];
      end
   end

   assign out_valid   = valid_ff;
   assign out_ctl     = ctl_ff;
   assign out_rem_row = rem_row_ff;
   assign out_shr_row = shr_row_ff;
   assign out_rem_col = rem_col_ff;
   assign out_shr_col = shr_col_ff;

endmodule

@@ rtl/nnsa_div_cell.sv @@
// ----------------------------------------------------------------------------
// nnsa_div_cell
// One restoring-division cell: retires one quotient bit for the row lane
// and one for the column lane, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module nnsa_div_cell import nnsa_pkg::*; #(
   parameter int DIM_W = 13,
   parameter int QUO_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  nnsa_ctl_type     in_ctl,
   input  logic [DIM_W-1:0] in_rem_row,
   input  logic [QUO_W-1:0] in_shr_row,
   input  logic [DIM_W-1:0] in_rem_col,
   input  logic [QUO_W-1:0] in_shr_col,
   input  logic [DIM_W-1:0] div_row,
   input  logic [DIM_W-1:0] div_col,
   output logic             out_valid,
   input  logic             out_ready,
   output nnsa_ctl_type     out_ctl,
   output logic [DIM_W-1:0] out_rem_row,
   output logic [QUO_W-1:0] out_shr_row,
   output logic [DIM_W-1:0] out_rem_col,
   output logic [QUO_W-1:0] out_shr_col
);

   logic             valid_ff;
   nnsa_ctl_type     ctl_ff;
   logic [DIM_W:0]   trial_row, trial_col;
   logic             ge_row, ge_col;
   logic [DIM_W-1:0] rem_row_in, rem_col_in, rem_row_ff, rem_col_ff;
   logic [QUO_W-1:0] shr_row_in, shr_col_in, shr_row_ff, shr_col_ff;

   assign in_ready = !valid_ff || out_ready;

   // Bring down the next numerator bit, subtract the divisor if it fits,
   // and shift the resulting quotient bit in at the bottom.
   always_comb begin
      trial_row  = {in_rem_row, in_shr_row[QUO_W-1]};
      ge_row     = (trial_row >= {1'b0, div_row});
      rem_row_in = ge_row ? DIM_W'(trial_row - {1'b0, div_row}) : trial_row[DIM_W-1:0];
      shr_row_in = {in_shr_row[QUO_W-2:0], ge_row};

      trial_col  = {in_rem_col, in_shr_col[QUO_W-1]};
      ge_col     = (trial_col >= {1'b0, div_col});
      rem_col_in = ge_col ? DIM_W'(trial_col - {1'b0, div_col}) : trial_col[DIM_W-1:0];
      shr_col_in = {in_shr_col[QUO_W-2:0], ge_col};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff     <= in_ctl;
         rem_row_ff <= rem_row_in;
         shr_row_ff <= shr_row_in;
         rem_col_ff <= rem_col_in;
         shr_col_ff <= shr_col_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_ctl     = ctl_ff;
   assign out_rem_row = rem_row_ff;
   assign out_shr_row = shr_row_ff;
   assign out_rem_col = rem_col_ff;
   assign out_shr_col = shr_col_ff;

endmodule

@@ rtl/nnsa_back.sv @@
// ----------------------------------------------------------------------------
// nnsa_back
// Exit stages: row mirroring and row-stride product, then the byte
// address sum into the output register.
// ----------------------------------------------------------------------------
module nnsa_back import nnsa_pkg::*; #(
   parameter int DIM_W = 13,
   parameter int QUO_W = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  nnsa_ctl_type        in_ctl,
   input  logic [QUO_W-1:0]    in_quo_row,
   input  logic [QUO_W-1:0]    in_quo_col,
   input  logic [DIM_W-1:0]    src_w,
   input  logic [DIM_W-1:0]    src_h,
   input  logic                src_top_down,
   input  logic [OFFSET_W-1:0] pixel_offset,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [COORD_W-1:0]  src_row,
   output logic [COORD_W-1:0]  src_col,
   output logic [ADDR_W-1:0]   byte_address,
   output logic                row_end,
   output logic [PAD_W-1:0]    dst_pad_bytes,
   output logic                coord_ok
);

   localparam int STRIDE_W = DIM_W + 2;
   localparam int PROD_W   = QUO_W + STRIDE_W;
   localparam int COL3_W   = QUO_W + 2;
   localparam int SUM_W    = ADDR_W + PROD_W;

   logic                valid_a_ff, valid_b_ff, ready_a, ready_b;
   nnsa_ctl_type        ctl_a_ff;
   logic [QUO_W-1:0]    row_sel, row_a_ff, col_a_ff;
   logic [STRIDE_W-1:0] stride;
   logic [PROD_W-1:0]   prod_in, prod_a_ff;
   logic [COL3_W-1:0]   col3_in, col3_a_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [COORD_W-1:0]  src_row_ff, src_col_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic                row_end_ff, ok_ff;
   logic [PAD_W-1:0]    pad_ff;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // Mirror top-down rows and form the row offset in bytes.
   always_comb begin
      row_sel = src_top_down ? (QUO_W'(src_h - DIM_W'(1)) - in_quo_row) : in_quo_row;
      stride  = STRIDE_W'({src_w, 1'b0}) + STRIDE_W'(src_w) +
                STRIDE_W'(row_pad(src_w[PAD_W-1:0]));
      prod_in = PROD_W'(row_sel) * PROD_W'(stride);
      col3_in = COL3_W'({in_quo_col, 1'b0}) + COL3_W'(in_quo_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= in_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         ctl_a_ff  <= in_ctl;
         row_a_ff  <= row_sel;
         col_a_ff  <= in_quo_col;
         prod_a_ff <= prod_in;
         col3_a_ff <= col3_in;
      end
   end

   // Byte address of the blue byte.
   assign sum_in = SUM_W'(pixel_offset) + SUM_W'(prod_a_ff) + SUM_W'(col3_a_ff);

   // Output register; a coordinate outside the destination gives all zeros.
   always_ff @(posedge clock) begin
      if (ready_b) begin
         ok_ff      <= ctl_a_ff.ok;
         src_row_ff <= ctl_a_ff.ok ? COORD_W'(row_a_ff) : '0;
         src_col_ff <= ctl_a_ff.ok ? COORD_W'(col_a_ff) : '0;
         addr_ff    <= ctl_a_ff.ok ? sum_in[ADDR_W-1:0] : '0;
         row_end_ff <= ctl_a_ff.ok && ctl_a_ff.row_end;
         pad_ff     <= ctl_a_ff.ok ? ctl_a_ff.dst_pad : '0;
      end
   end

   assign out_valid     = valid_b_ff;
   assign src_row       = src_row_ff;
   assign src_col       = src_col_ff;
   assign byte_address  = addr_ff;
   assign row_end       = row_end_ff;
   assign dst_pad_bytes = pad_ff;
   assign coord_ok      = ok_ff;

endmodule

@@ rtl/nearest_neighbor_scale_address_top.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_top
// Nearest-neighbor scaling address generator for 24-bit padded bitmaps.
// ----------------------------------------------------------------------------
// Each request beat carries a destination coordinate; each response beat
// carries the chosen source row and column, the source byte address, the
// row-end flag with its destination padding, and an in-range flag. The
// block takes one beat per clock when not back-pressured and returns
// results in order. It has one entry stage, a chain of QUO_W =
// clog2(min(MAX_DIM, 8191)) division cells that each retire one quotient
// bit of both divisions, and two exit stages for the stride multiply and
// the address sum. The user must write configuration through the csr port
// while no beat is in flight; the block itself does not enforce this.
module nearest_neighbor_scale_address_top import nnsa_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request: out_row [11:0], out_col [23:12].
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response: src_row [11:0], src_col [23:12], byte_address [49:24],
   // dst_pad_bytes [51:50], zero fill above.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // Response user: coord_ok [0].
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int REG_MAX = (1 << DIM_REG_W) - 1;
   localparam int EFF_MAX = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
   localparam int DIM_W   = $clog2(EFF_MAX + 1);
   localparam int QUO_W   = $clog2(EFF_MAX);

   logic [DIM_REG_W-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic                 top_down_ff;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [DIM_W-1:0]     src_w, src_h, dst_w, dst_h;

   logic                 chain_valid [QUO_W+1];
   logic                 chain_ready [QUO_W+1];
   nnsa_ctl_type         chain_ctl   [QUO_W+1];
   logic [DIM_W-1:0]     chain_rem_row [QUO_W+1];
   logic [QUO_W-1:0]     chain_shr_row [QUO_W+1];
   logic [DIM_W-1:0]     chain_rem_col [QUO_W+1];
   logic [QUO_W-1:0]     chain_shr_col [QUO_W+1];

   logic [COORD_W-1:0]   src_row, src_col;
   logic [ADDR_W-1:0]    byte_address;
   logic [PAD_W-1:0]     dst_pad_bytes;

   // A dimension of zero acts as one; one above the limit acts as the limit.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (32'(v) > EFF_MAX) begin
         return DIM_W'(EFF_MAX);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= DIM_RESET;
         src_h_ff    <= DIM_RESET;
         top_down_ff <= 1'b0;
         dst_w_ff    <= DIM_RESET;
         dst_h_ff    <= DIM_RESET;
         offset_ff   <= OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:   src_w_ff    <= csr_wdata[DIM_REG_W-1:0];
            CSR_SRC_HEIGHT:  src_h_ff    <= csr_wdata[DIM_REG_W-1:0];
            CSR_SRC_TOPDOWN: top_down_ff <= csr_wdata[0];
            CSR_DST_WIDTH:   dst_w_ff    <= csr_wdata[DIM_REG_W-1:0];
            CSR_DST_HEIGHT:  dst_h_ff    <= csr_wdata[DIM_REG_W-1:0];
            CSR_PIXEL_OFS:   offset_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign src_w = eff_dim(src_w_ff);
   assign src_h = eff_dim(src_h_ff);
   assign dst_w = eff_dim(dst_w_ff);
   assign dst_h = eff_dim(dst_h_ff);

   // Entry stage.
   nnsa_front #(
      .DIM_W (DIM_W),
      .QUO_W (QUO_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .out_row     (req_tdata[COORD_W-1:0]),
      .out_col     (req_tdata[2*COORD_W-1:COORD_W]),
      .src_w       (src_w),
      .src_h       (src_h),
      .dst_w       (dst_w),
      .dst_h       (dst_h),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_ctl     (chain_ctl[0]),
      .out_rem_row (chain_rem_row[0]),
      .out_shr_row (chain_shr_row[0]),
      .out_rem_col (chain_rem_col[0]),
      .out_shr_col (chain_shr_col[0])
   );

   // Division chain, one quotient bit per cell, most significant first.
   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      nnsa_div_cell #(
         .DIM_W (DIM_W),
         .QUO_W (QUO_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (chain_valid[i]),
         .in_ready    (chain_ready[i]),
         .in_ctl      (chain_ctl[i]),
         .in_rem_row  (chain_rem_row[i]),
         .in_shr_row  (chain_shr_row[i]),
         .in_rem_col  (chain_rem_col[i]),
         .in_shr_col  (chain_shr_col[i]),
         .div_row     (dst_h),
         .div_col     (dst_w),
         .out_valid   (chain_valid[i+1]),
         .out_ready   (chain_ready[i+1]),
         .out_ctl     (chain_ctl[i+1]),
         .out_rem_row (chain_rem_row[i+1]),
         .out_shr_row (chain_shr_row[i+1]),
         .out_rem_col (chain_rem_col[i+1]),
         .out_shr_col (chain_shr_col[i+1])
      );
   end

   // Exit stages.
   nnsa_back #(
      .DIM_W (DIM_W),
      .QUO_W (QUO_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[QUO_W]),
      .in_ready      (chain_ready[QUO_W]),
      .in_ctl        (chain_ctl[QUO_W]),
      .in_quo_row    (chain_shr_row[QUO_W]),
      .in_quo_col    (chain_shr_col[QUO_W]),
      .src_w         (src_w),
      .src_h         (src_h),
      .src_top_down  (top_down_ff),
      .pixel_offset  (offset_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .src_row       (src_row),
      .src_col       (src_col),
      .byte_address  (byte_address),
      .row_end       (rsp_tlast),
      .dst_pad_bytes (dst_pad_bytes),
      .coord_ok      (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, dst_pad_bytes, byte_address, src_col, src_row};

   // A coordinate outside the destination returns an all-zero beat.
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("out-of-range beat carries nonzero fields");

   // Destination padding only follows the last pixel of a row.
   a_pad_at_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[51:50] == '0))
      else $error("padding reported away from row end");

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor scale address generator.
// A clocked driver sends destination coordinates from a queue, a clocked
// monitor compares each response beat against a local prediction of the
// source row, column, byte address, row-end flag, padding and range flag.
// Geometry is changed between phases while the block is idle, covering
// the dimension extremes, top-down sources and ignored register indexes.
// ----------------------------------------------------------------------------
module testbench import nnsa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM_TB      = 4096;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 115;
   localparam int PRESSURE_AT     = 200;
   localparam int PRESSURE_CYCLES = 300;
   localparam int TIMEOUT_NS      = 2_000_000;

   // Register indexes that decode to nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   // One predicted response beat.
   typedef struct packed {
      logic [COORD_W-1:0] src_row;
      logic [COORD_W-1:0] src_col;
      logic [ADDR_W-1:0]  byte_address;
      logic               row_end;
      logic [PAD_W-1:0]   dst_pad_bytes;
      logic               coord_ok;
   } pixel_fetch_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Local copy of the geometry registers.
   logic [DIM_REG_W-1:0]  geo_src_width  = DIM_RESET;
   logic [DIM_REG_W-1:0]  geo_src_height = DIM_RESET;
   logic                  geo_top_down   = 1'b0;
   logic [DIM_REG_W-1:0]  geo_dst_width  = DIM_RESET;
   logic [DIM_REG_W-1:0]  geo_dst_height = DIM_RESET;
   logic [OFFSET_W-1:0]   geo_offset     = OFFSET_RESET;

   logic [REQ_DATA_W-1:0] pending_coords[$];
   pixel_fetch_type       expected_fetches[$];
   int                    error_count  = 0;
   int                    result_count = 0;
   int                    send_gap     = 0;
   int                    recv_stall   = 0;
   bit                    gaps_on      = 1'b1;
   bit                    pressure_done = 1'b0;

   nearest_neighbor_scale_address_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A zero dimension behaves as one, an oversized one as the maximum.
   function automatic longint unsigned clamp_dim(input logic [DIM_REG_W-1:0] v);
      if (v == '0) return 64'd1;
      if (64'(v) > 64'(MAX_DIM_TB)) return 64'(MAX_DIM_TB);
      return 64'(v);
   endfunction

   // Bytes needed to bring a row of w 24-bit pixels to a multiple of four.
   function automatic longint unsigned row_pad_bytes(input longint unsigned w);
      return (64'd4 - ((w * 64'd3) & 64'd3)) & 64'd3;
   endfunction

   // Source pixel and address for one destination coordinate.
   function automatic pixel_fetch_type predict_fetch(input logic [REQ_DATA_W-1:0] coord);
      longint unsigned orow, ocol, sw, sh, dw, dh, row, col, addr;
      pixel_fetch_type f;
      f    = '0;
      orow = 64'(coord[COORD_W-1:0]);
      ocol = 64'(coord[2*COORD_W-1:COORD_W]);
      sw   = clamp_dim(geo_src_width);
      sh   = clamp_dim(geo_src_height);
      dw   = clamp_dim(geo_dst_width);
      dh   = clamp_dim(geo_dst_height);
      if (orow >= dh || ocol >= dw) return f;
      row = (orow * sh) / dh;
      col = (ocol * sw) / dw;
      if (geo_top_down) row = sh - 64'd1 - row;
      addr = 64'(geo_offset) + row * (64'd3 * sw + row_pad_bytes(sw)) + 64'd3 * col;
      f.src_row      = row[COORD_W-1:0];
      f.src_col      = col[COORD_W-1:0];
      f.byte_address = addr[ADDR_W-1:0];
      f.row_end      = (ocol == dw - 64'd1);
      f.dst_pad_bytes = f.row_end ? PAD_W'(row_pad_bytes(dw)) : '0;
      f.coord_ok     = 1'b1;
      return f;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Register word for a dimension, sometimes out of range or with high junk.
   function automatic logic [CSR_DATA_W-1:0] random_dim_word();
      int r;
      logic [CSR_DATA_W-1:0] w;
      r = $urandom_range(0, 99);
      if (r < 35)      w = CSR_DATA_W'($urandom_range(1, 16));
      else if (r < 75) w = CSR_DATA_W'($urandom_range(1, MAX_DIM_TB));
      else if (r < 85) w = CSR_DATA_W'(MAX_DIM_TB);
      else if (r < 90) w = '0;
      else             w = CSR_DATA_W'($urandom_range(MAX_DIM_TB + 1, 8191));
      if ($urandom_range(0, 4) == 0) begin
         w[CSR_DATA_W-1:DIM_REG_W] = (CSR_DATA_W-DIM_REG_W)'($urandom_range(0, 7));
      end
      return w;
   endfunction

   // Mostly coordinates inside the destination, row ends favored.
   function automatic logic [REQ_DATA_W-1:0] random_coord();
      int r;
      int unsigned dw, dh, row, col;
      dw  = 32'(clamp_dim(geo_dst_width));
      dh  = 32'(clamp_dim(geo_dst_height));
      r   = $urandom_range(0, 99);
      row = $urandom_range(0, dh - 1);
      col = ($urandom_range(0, 3) == 0) ? dw - 1 : $urandom_range(0, dw - 1);
      if (r >= 90) begin
         row = $urandom_range(0, 4095);
         col = $urandom_range(0, 4095);
      end else if (r >= 80) begin
         if ($urandom_range(0, 1) && dh < MAX_DIM_TB) row = dh;
         else if (dw < MAX_DIM_TB) col = dw;
         else row = $urandom_range(0, 4095);
      end
      return {col[COORD_W-1:0], row[COORD_W-1:0]};
   endfunction

   task automatic push_coord(input int unsigned row, input int unsigned col);
      pending_coords.push_back({col[COORD_W-1:0], row[COORD_W-1:0]});
   endtask

   // One register write; the write enable stays high until csr_idle.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SRC_WIDTH:   geo_src_width  = value[DIM_REG_W-1:0];
         CSR_SRC_HEIGHT:  geo_src_height = value[DIM_REG_W-1:0];
         CSR_SRC_TOPDOWN: geo_top_down   = value[0];
         CSR_DST_WIDTH:   geo_dst_width  = value[DIM_REG_W-1:0];
         CSR_DST_HEIGHT:  geo_dst_height = value[DIM_REG_W-1:0];
         CSR_PIXEL_OFS:   geo_offset     = value[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] sw, sh, td, dw, dh, ofs);
      csr_write(CSR_SRC_WIDTH, sw);
      csr_write(CSR_SRC_HEIGHT, sh);
      csr_write(CSR_SRC_TOPDOWN, td);
      csr_write(CSR_DST_WIDTH, dw);
      csr_write(CSR_DST_HEIGHT, dh);
      csr_write(CSR_PIXEL_OFS, ofs);
   endtask

   // Wait until every queued beat is sent and answered, then a margin.
   task automatic wait_idle();
      while (pending_coords.size() != 0 || req_tvalid || expected_fetches.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Request driver: holds a beat until taken, then waits out a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_fetches.push_back(predict_fetch(req_tdata));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_coords.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_coords.pop_front();
               send_gap = gaps_on ? idle_length() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Response monitor: checks each beat and stalls the response side.
   always @(posedge clock) begin
      pixel_fetch_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_fetches.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = expected_fetches.pop_front();
               check_field("src_row", want.src_row, rsp_tdata[11:0]);
               check_field("src_col", want.src_col, rsp_tdata[23:12]);
               check_field("byte_address", want.byte_address, rsp_tdata[49:24]);
               check_field("dst_pad_bytes", want.dst_pad_bytes, rsp_tdata[51:50]);
               check_field("tdata fill", 64'd0, rsp_tdata[RSP_DATA_W-1:52]);
               check_field("row_end", want.row_end, rsp_tlast);
               check_field("coord_ok", want.coord_ok, rsp_tuser);
            end
         end
         // One long hold-off so the pipeline fills and backs up the input.
         if (!pressure_done && result_count >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            recv_stall    = PRESSURE_CYCLES;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = gaps_on ? idle_length() : 0;
         end
      end
   end

   // Stimulus: directed geometries first, then random ones.
   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Geometry after reset: everything is a single pixel.
      push_coord(0, 0);
      push_coord(0, 1);
      push_coord(1, 0);
      push_coord(4095, 4095);
      push_coord(0, 4095);
      wait_idle();

      // Largest source and destination, largest offset.
      set_geometry(16'd4096, 16'd4096, 16'd0, 16'd4096, 16'd4096, 16'hFFFF);
      csr_idle();
      push_coord(4095, 4095);
      push_coord(0, 0);
      push_coord(4095, 0);
      push_coord(0, 4095);
      wait_idle();

      // Zero and oversized dimensions, top-down source, padded row end.
      set_geometry(16'd0, 16'h1FFF, 16'd1, 16'd3, 16'd5000, 16'd0);
      csr_idle();
      push_coord(0, 2);
      push_coord(4095, 0);
      push_coord(1, 3);
      push_coord(4095, 2);
      wait_idle();

      // Small odd sizes; writes to undecoded indexes must change nothing.
      set_geometry(16'd5, 16'd7, 16'hFFFF, 16'd2, 16'd3, 16'd1000);
      csr_write(CSR_UNUSED_LO, 16'd1);
      csr_write(CSR_UNUSED_HI, 16'hFFFF);
      csr_idle();
      push_coord(2, 1);
      push_coord(0, 0);
      push_coord(3, 0);
      push_coord(2, 2);
      push_coord(1, 1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         set_geometry(random_dim_word(), random_dim_word(),
                      CSR_DATA_W'($urandom_range(0, 65535)),
                      random_dim_word(), random_dim_word(),
                      CSR_DATA_W'($urandom_range(0, 65535)));
         if ($urandom_range(0, 2) == 0) begin
            csr_write(CSR_UNUSED_HI, CSR_DATA_W'($urandom_range(0, 65535)));
         end
         csr_idle();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_coords.push_back(random_coord());
         wait_idle();
      end

      if (error_count == 0 && expected_fetches.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #TIMEOUT_NS;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/nnsa_pkg.sv
rtl/nnsa_front.sv
rtl/nnsa_div_cell.sv
rtl/nnsa_back.sv
rtl/nearest_neighbor_scale_address_top.sv
tb/testbench.sv
